// ===== design/tevq_pkg.sv =====
// ----------------------------------------------------------------------------
// tevq_pkg
// Shared types, codes and the time key function of the timed event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tevq_pkg;

	// Operation codes
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_POP = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_ADDED   = 2'd0;
	localparam logic [1:0] STATUS_POPPED  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [1:0] STATUS_DROPPED = 2'd3;

	localparam int KEY_W   = 18;  // 63*3600 + 63*60 + 63 fits in 18 bits
	localparam int ORDER_W = 16;

	typedef struct packed {
		logic       op;
		logic [7:0] client_id;
		logic [5:0] in_hours;
		logic [5:0] in_minutes;
		logic [5:0] in_seconds;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_client;
		logic [5:0] out_hours;
		logic [5:0] out_minutes;
		logic [5:0] out_seconds;
	} rsp_t;

	// One stored event, valid flag kept in the memory word
	typedef struct packed {
		logic               valid;
		logic [7:0]         client;
		logic [5:0]         hours;
		logic [5:0]         minutes;
		logic [5:0]         seconds;
		logic [ORDER_W-1:0] order;
	} entry_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_REMOVE
	} fsm_t;

	// Seconds-of-day style key: hours*3600 + minutes*60 + seconds
	function automatic logic [KEY_W-1:0] time_key(input logic [5:0] h,
		input logic [5:0] m, input logic [5:0] s);
		logic [KEY_W-1:0] kh;
		logic [KEY_W-1:0] km;
		kh = {{(KEY_W-6){1'b0}}, h} * KEY_W'(3600);
		km = {{(KEY_W-6){1'b0}}, m} * KEY_W'(60);
		return kh + km + {{(KEY_W-6){1'b0}}, s};
	endfunction

endpackage

`default_nettype wire

// ===== design/tevq_best.sv =====
// ----------------------------------------------------------------------------
// tevq_best
// Running minimum over the entries streamed out of the queue memory: one
// key/age stage, then compare against the best entry seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module tevq_best #(
	parameter int AW = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          scan_start,
	input  wire logic [tevq_pkg::ORDER_W-1:0]  seq,
	input  wire logic                          cand_vld,
	input  wire logic [AW-1:0]                 cand_addr,
	input  wire tevq_pkg::entry_t              cand_entry,
	output logic                               pending,
	output logic [AW-1:0]                      best_addr,
	output tevq_pkg::entry_t                   best_entry
);
	import tevq_pkg::*;

	logic               vld_s2;
	logic [AW-1:0]      addr_s2;
	entry_t             entry_s2;
	logic [KEY_W-1:0]   key_s2;
	logic [ORDER_W-1:0] age_s2;

	logic               found_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [ORDER_W-1:0] best_age_q;
	logic [AW-1:0]      best_addr_q;
	entry_t             best_entry_q;
	logic               better;

	// Key and age stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= cand_vld && !scan_start;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2  <= cand_addr;
		entry_s2 <= cand_entry;
		key_s2   <= time_key(cand_entry.hours, cand_entry.minutes, cand_entry.seconds);
		age_s2   <= seq - cand_entry.order;
	end

	// Earlier key wins; on equal keys the older entry wins
	assign better = !found_q || (key_s2 < best_key_q) ||
		((key_s2 == best_key_q) && (age_s2 > best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (scan_start) begin
			found_q <= 1'b0;
		end else if (vld_s2 && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && better) begin
			best_key_q   <= key_s2;
			best_age_q   <= age_s2;
			best_addr_q  <= addr_s2;
			best_entry_q <= entry_s2;
		end
	end

	assign pending    = vld_s2;
	assign best_addr  = best_addr_q;
	assign best_entry = best_entry_q;

endmodule

`default_nettype wire

// ===== design/timed_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Timed event queue: stores client ids with hh:mm:ss stamps, pops earliest.
// ----------------------------------------------------------------------------
// After reset the block clears every slot of the entry memory
// with busy high. A command is taken when start is high and busy is low;
// its single result appears on result for one cycle with done high and
// cannot be held off. An add into a full queue or a pop from an empty one
// answers on the next cycle. An add walks the memory from slot 0 to the
// lowest free slot, one read per cycle. A pop reads every slot once
// through the one memory read port and a key/compare stage, then writes
// the winner back as free.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_queue_core #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire tevq_pkg::req_t request,
	output logic                busy,
	output logic                done,
	output tevq_pkg::rsp_t      result
);
	import tevq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(QUEUE_DEPTH - 1);

	// Entry memory, one read and one write port
	entry_t mem [QUEUE_DEPTH];

	fsm_t               state_q, state_d;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      count_q;
	logic [ORDER_W-1:0] seq_q;
	req_t               req_q;
	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	entry_t             rdata_s1;
	logic               done_q;
	rsp_t               result_q;

	logic               accept;
	logic               issue;
	logic               found_free;
	logic               pop_end;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	logic               res_fire;
	rsp_t               res_next;
	logic               cnt_inc;
	logic               cnt_dec;
	logic               scan_start;

	logic               best_pending;
	logic [AW-1:0]      best_addr;
	entry_t             best_entry;

	assign accept     = start && (state_q == FSM_IDLE);
	assign issue      = (state_q == FSM_SCAN) && (cnt_q != DEPTH_C);
	assign found_free = (state_q == FSM_SCAN) && (req_q.op == OP_ADD) &&
		vld_s1 && !rdata_s1.valid;
	assign pop_end    = (state_q == FSM_SCAN) && (req_q.op == OP_POP) &&
		(cnt_q == DEPTH_C) && !vld_s1 && !best_pending;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_CLEAR: begin
				if (cnt_q == LAST_C) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (start) begin
					if (request.op == OP_ADD && count_q != DEPTH_C) state_d = FSM_SCAN;
					if (request.op == OP_POP && count_q != '0)      state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (found_free)   state_d = FSM_IDLE;
				else if (pop_end) state_d = FSM_REMOVE;
			end
			FSM_REMOVE: state_d = FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	// Outputs of the state machine: memory write, result, counters
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = cnt_q[AW-1:0];
		wr_data    = best_entry;
		res_fire   = 1'b0;
		res_next   = '0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		scan_start = 1'b0;
		unique case (state_q)
			FSM_CLEAR: begin
				wr_en         = 1'b1;
				wr_data       = '0;
			end
			FSM_IDLE: begin
				scan_start = accept;
				if (accept && request.op == OP_ADD && count_q == DEPTH_C) begin
					res_fire        = 1'b1;
					res_next.status = STATUS_DROPPED;
				end
				if (accept && request.op == OP_POP && count_q == '0) begin
					res_fire        = 1'b1;
					res_next.status = STATUS_EMPTY;
				end
			end
			FSM_SCAN: begin
				if (found_free) begin
					wr_en           = 1'b1;
					wr_addr         = addr_s1;
					wr_data.valid   = 1'b1;
					wr_data.client  = req_q.client_id;
					wr_data.hours   = req_q.in_hours;
					wr_data.minutes = req_q.in_minutes;
					wr_data.seconds = req_q.in_seconds;
					wr_data.order   = seq_q;
					res_fire        = 1'b1;
					res_next.status = STATUS_ADDED;
					cnt_inc         = 1'b1;
				end
			end
			FSM_REMOVE: begin
				wr_en                = 1'b1;
				wr_addr              = best_addr;
				wr_data.valid        = 1'b0;
				res_fire             = 1'b1;
				res_next.status      = STATUS_POPPED;
				res_next.out_client  = best_entry.client;
				res_next.out_hours   = best_entry.hours;
				res_next.out_minutes = best_entry.minutes;
				res_next.out_seconds = best_entry.seconds;
				cnt_dec              = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			cnt_q   <= '0;
			count_q <= '0;
			seq_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			done_q  <= res_fire;
			if (state_q == FSM_CLEAR) begin
				cnt_q <= (cnt_q == LAST_C) ? '0 : cnt_q + CW'(1);
			end else if (accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
				seq_q   <= seq_q + ORDER_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) req_q <= request;
		if (res_fire) result_q <= res_next;
		addr_s1 <= cnt_q[AW-1:0];
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_s1 <= mem[cnt_q[AW-1:0]];
	end

	tevq_best #(
		.AW(AW)
	) u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_start (scan_start),
		.seq        (seq_q),
		.cand_vld   (vld_s1 && rdata_s1.valid && (req_q.op == OP_POP) &&
			(state_q == FSM_SCAN)),
		.cand_addr  (addr_s1),
		.cand_entry (rdata_s1),
		.pending    (best_pending),
		.best_addr  (best_addr),
		.best_entry (best_entry)
	);

	assign busy   = (state_q != FSM_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
